### src/ssr_pkg.sv
package ssr_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int WORD_W    = 32;
	localparam int ACC_W     = 56;
	localparam int PROD_W    = 54;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CPOS_W    = 11;
	localparam int APOS_W    = 10;
	localparam int SPREAD    = 23;
	localparam int MONO_Q24  = 335544;

	localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_DIRECT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_CROSS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMB_FEEDBACK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMP_KEEP     = 3'd4;

	localparam int COMB_LEN [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_LEN   [4] = '{556, 441, 341, 225};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} out_beat_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DRV0, ST_DRV1,
		ST_CRD, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6,
		ST_SUM, ST_ARD, ST_A1,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_FIN
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLEAR, OP_LOAD, OP_DRIVE, OP_CRD, OP_C1, OP_C4, OP_C6,
		OP_SUM, OP_ARD, OP_A1, OP_M4, OP_FIN
	} dp_op_t;

	typedef enum logic [2:0] {
		MA_XSUM, MA_COMB_OUT, MA_LPM, MA_LP, MA_XIN, MA_REV_OWN, MA_REV_OTHER
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_MONO, MB_DAMP_NEW, MB_DAMP, MB_FB, MB_DRY, MB_WD, MB_WC
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD
	} acc_op_t;

	typedef struct packed {
		dp_op_t  op;
		mul_a_t  ma;
		mul_b_t  mb;
		acc_op_t acc;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic comb_last;
		logic ap_last;
		logic ch_last;
		logic out_busy;
	} sts_t;

	function automatic int comb_total(int nc);
		int t;
		t = 0;
		for (int k = 0; k < nc; k++) t += 2 * COMB_LEN[k] + SPREAD;
		return t;
	endfunction

	function automatic int ap_total(int na);
		int t;
		t = 0;
		for (int k = 0; k < na; k++) t += 2 * AP_LEN[k] + SPREAD;
		return t;
	endfunction

	function automatic logic [CPOS_W-1:0] comb_len_f(logic [2:0] k);
		return CPOS_W'(COMB_LEN[k]);
	endfunction

	function automatic logic [APOS_W-1:0] ap_len_f(logic [1:0] k);
		return APOS_W'(AP_LEN[k]);
	endfunction

	function automatic logic signed [ACC_W-1:0] rnd16(logic signed [ACC_W-1:0] v);
		return (v + ACC_W'(32768)) >>> 16;
	endfunction

	function automatic logic signed [WORD_W-1:0] sat32(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7FFF_FFFF);
		lo = -hi - ACC_W'(1);
		if (v > hi) return WORD_W'(hi);
		if (v < lo) return WORD_W'(lo);
		return WORD_W'(v);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat24(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(32'sh7F_FFFF);
		lo = -hi - ACC_W'(1);
		if (v > hi) return SAMPLE_W'(hi);
		if (v < lo) return SAMPLE_W'(lo);
		return SAMPLE_W'(v);
	endfunction

endpackage

### src/ssr_ram.sv
module ssr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### src/ssr_ctrl.sv
module ssr_ctrl import ssr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '{op: OP_NONE, ma: MA_XSUM, mb: MB_MONO, acc: ACC_HOLD};
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DRV0;
				end
			end
			ST_DRV0: begin
				cmd.ma  = MA_XSUM;
				cmd.mb  = MB_MONO;
				state_d = ST_DRV1;
			end
			ST_DRV1: begin
				cmd.op  = OP_DRIVE;
				state_d = ST_CRD;
			end
			ST_CRD: begin
				cmd.op  = OP_CRD;
				state_d = ST_C1;
			end
			ST_C1: begin
				cmd.op  = OP_C1;
				cmd.ma  = MA_COMB_OUT;
				cmd.mb  = MB_DAMP_NEW;
				state_d = ST_C2;
			end
			ST_C2: begin
				cmd.ma  = MA_LPM;
				cmd.mb  = MB_DAMP;
				cmd.acc = ACC_LOAD;
				state_d = ST_C3;
			end
			ST_C3: begin
				cmd.acc = ACC_ADD;
				state_d = ST_C4;
			end
			ST_C4: begin
				cmd.op  = OP_C4;
				state_d = ST_C5;
			end
			ST_C5: begin
				cmd.ma  = MA_LP;
				cmd.mb  = MB_FB;
				state_d = ST_C6;
			end
			ST_C6: begin
				cmd.op  = OP_C6;
				state_d = sts.comb_last ? ST_SUM : ST_CRD;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_ARD;
			end
			ST_ARD: begin
				cmd.op  = OP_ARD;
				state_d = ST_A1;
			end
			ST_A1: begin
				cmd.op = OP_A1;
				if (!sts.ap_last) state_d = ST_ARD;
				else if (sts.ch_last) state_d = ST_M0;
				else state_d = ST_CRD;
			end
			ST_M0: begin
				cmd.ma  = MA_XIN;
				cmd.mb  = MB_DRY;
				state_d = ST_M1;
			end
			ST_M1: begin
				cmd.ma  = MA_REV_OWN;
				cmd.mb  = MB_WD;
				cmd.acc = ACC_LOAD;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.ma  = MA_REV_OTHER;
				cmd.mb  = MB_WC;
				cmd.acc = ACC_ADD;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.acc = ACC_ADD;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.op  = OP_M4;
				state_d = sts.ch_last ? ST_FIN : ST_M0;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### src/ssr_dp.sv
module ssr_dp import ssr_pkg::*; #(
	parameter int NC = 4,
	parameter int NA = 2,
	parameter int COMB_DEPTH = 9966,
	parameter int AP_DEPTH = 2040,
	parameter int CLR_N = 9966,
	localparam int CA_W = (COMB_DEPTH > 1) ? $clog2(COMB_DEPTH) : 1,
	localparam int AA_W = (AP_DEPTH > 1) ? $clog2(AP_DEPTH) : 1,
	localparam int CB_W = $clog2(COMB_DEPTH + 1),
	localparam int AB_W = $clog2(AP_DEPTH + 1),
	localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1,
	localparam int KW = (NC > 1) ? $clog2(NC) : 1,
	localparam int JW = (NA > 1) ? $clog2(NA) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  in_beat_t             in_data,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output out_beat_t            out_data
);

	logic [16:0] dry_q;
	logic [19:0] wd_q;
	logic [18:0] wc_q;
	logic [15:0] fb_q;
	logic [15:0] dk_q;

	logic signed [SAMPLE_W-1:0] xin_q [2];
	logic signed [WORD_W-1:0]   drive_q, lp_q, x_q;
	logic signed [WORD_W-1:0]   rev_q [2];
	logic signed [SAMPLE_W-1:0] res_q [2];
	logic signed [WORD_W-1:0]   lpm_q [2][NC];
	logic [CPOS_W-1:0]          cpos_q [2][NC];
	logic [APOS_W-1:0]          apos_q [2][NA];
	logic signed [34:0]         sum_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [CB_W-1:0]            cbase_q;
	logic [AB_W-1:0]            abase_q;
	logic [CA_W-1:0]            caddr_q;
	logic [AA_W-1:0]            aaddr_q;
	logic                       ch_q;
	logic [KW-1:0]              k_q;
	logic [JW-1:0]              j_q;
	logic [CLR_W-1:0]           clr_q;
	logic                       out_valid_q;
	out_beat_t                  out_q;

	logic signed [32:0]       mul_a;
	logic signed [20:0]       mul_b;
	logic [CPOS_W-1:0]        clen, cpos, cpos_nx;
	logic [APOS_W-1:0]        alen, apos, apos_nx;
	logic [CB_W-1:0]          caddr_w;
	logic [AB_W-1:0]          aaddr_w;
	logic [CA_W-1:0]          comb_addr;
	logic [AA_W-1:0]          ap_addr;
	logic                     comb_we, ap_we;
	logic [WORD_W-1:0]        comb_wdata, ap_wdata, comb_rdata, ap_rdata;
	logic signed [WORD_W-1:0] comb_out, ap_held, comb_new, lp_new, ap_new, ap_x;

	// line geometry of the current comb and allpass
	assign clen    = comb_len_f(3'(k_q)) + (ch_q ? CPOS_W'(SPREAD) : CPOS_W'(0));
	assign alen    = ap_len_f(2'(j_q)) + (ch_q ? APOS_W'(SPREAD) : APOS_W'(0));
	assign cpos    = cpos_q[ch_q][k_q];
	assign apos    = apos_q[ch_q][j_q];
	assign cpos_nx = (cpos == clen - CPOS_W'(1)) ? CPOS_W'(0) : cpos + CPOS_W'(1);
	assign apos_nx = (apos == alen - APOS_W'(1)) ? APOS_W'(0) : apos + APOS_W'(1);
	assign caddr_w = cbase_q + CB_W'(cpos);
	assign aaddr_w = abase_q + AB_W'(apos);

	assign comb_out = signed'(comb_rdata);
	assign ap_held  = signed'(ap_rdata);
	assign lp_new   = sat32(rnd16(acc_q));
	assign comb_new = sat32(ACC_W'(drive_q) + rnd16(ACC_W'(prod_s1)));
	assign ap_new   = sat32(ACC_W'(x_q) + ((ACC_W'(ap_held) + ACC_W'(1)) >>> 1));
	assign ap_x     = sat32(ACC_W'(ap_held) - ACC_W'(x_q));

	always_comb begin
		unique case (cmd.ma)
			MA_XSUM:      mul_a = 33'(xin_q[0]) + 33'(xin_q[1]);
			MA_COMB_OUT:  mul_a = 33'(comb_out);
			MA_LPM:       mul_a = 33'(lpm_q[ch_q][k_q]);
			MA_LP:        mul_a = 33'(lp_q);
			MA_XIN:       mul_a = 33'(xin_q[ch_q]);
			MA_REV_OWN:   mul_a = 33'(rev_q[ch_q]);
			MA_REV_OTHER: mul_a = 33'(rev_q[~ch_q]);
			default:      mul_a = '0;
		endcase
		unique case (cmd.mb)
			MB_MONO:     mul_b = 21'(MONO_Q24);
			MB_DAMP_NEW: mul_b = signed'({4'd0, 17'd65536 - 17'(dk_q)});
			MB_DAMP:     mul_b = signed'({5'd0, dk_q});
			MB_FB:       mul_b = signed'({5'd0, fb_q});
			MB_DRY:      mul_b = signed'({4'd0, dry_q});
			MB_WD:       mul_b = signed'({1'b0, wd_q});
			MB_WC:       mul_b = signed'({2'd0, wc_q});
			default:     mul_b = '0;
		endcase
	end

	// memory ports: sweep address while clearing, held address on write-back
	always_comb begin
		comb_we    = 1'b0;
		ap_we      = 1'b0;
		comb_wdata = comb_new;
		ap_wdata   = ap_new;
		comb_addr  = caddr_w[CA_W-1:0];
		ap_addr    = aaddr_w[AA_W-1:0];
		if (cmd.op == OP_CLEAR) begin
			comb_addr  = CA_W'(clr_q);
			ap_addr    = AA_W'(clr_q);
			comb_we    = (clr_q < CLR_W'(COMB_DEPTH));
			ap_we      = (clr_q < CLR_W'(AP_DEPTH));
			comb_wdata = '0;
			ap_wdata   = '0;
		end else if (cmd.op == OP_C6) begin
			comb_addr = caddr_q;
			comb_we   = 1'b1;
		end else if (cmd.op == OP_A1) begin
			ap_addr = aaddr_q;
			ap_we   = 1'b1;
		end
	end

	ssr_ram #(.WIDTH(WORD_W), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (comb_we),
		.addr  (comb_addr),
		.wdata (comb_wdata),
		.rdata (comb_rdata)
	);

	ssr_ram #(.WIDTH(WORD_W), .DEPTH(AP_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.addr  (ap_addr),
		.wdata (ap_wdata),
		.rdata (ap_rdata)
	);

	// payload path
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		unique case (cmd.acc)
			ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default:  acc_q <= acc_q;
		endcase
		unique case (cmd.op)
			OP_LOAD: begin
				xin_q[0] <= in_data.left_in;
				xin_q[1] <= in_data.right_in;
			end
			OP_DRIVE: begin
				drive_q <= WORD_W'((prod_s1 + PROD_W'(1 << 23)) >>> 24);
				sum_q   <= '0;
			end
			OP_CRD: caddr_q <= caddr_w[CA_W-1:0];
			OP_C1:  sum_q <= sum_q + 35'(comb_out);
			OP_C4:  lp_q <= lp_new;
			OP_SUM: x_q <= sat32(ACC_W'(sum_q));
			OP_ARD: aaddr_q <= aaddr_w[AA_W-1:0];
			OP_A1: begin
				x_q <= ap_x;
				if (sts.ap_last) begin
					rev_q[ch_q] <= ap_x;
					sum_q       <= '0;
				end
			end
			OP_M4: res_q[ch_q] <= sat24(rnd16(acc_q));
			default: ;
		endcase
	end

	// line state, counters and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q       <= 17'd65536;
			wd_q        <= '0;
			wc_q        <= '0;
			fb_q        <= 16'd45875;
			dk_q        <= 16'd5243;
			cbase_q     <= '0;
			abase_q     <= '0;
			ch_q        <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < NC; k++) begin
					lpm_q[c][k]  <= '0;
					cpos_q[c][k] <= '0;
				end
				for (int k = 0; k < NA; k++) apos_q[c][k] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_DRY_GAIN:      dry_q <= cfg_data[16:0];
					CFG_WET_DIRECT:    wd_q  <= cfg_data[19:0];
					CFG_WET_CROSS:     wc_q  <= cfg_data[18:0];
					CFG_COMB_FEEDBACK: fb_q  <= cfg_data[15:0];
					CFG_DAMP_KEEP:     dk_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_FIN) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + CLR_W'(1);
				OP_DRIVE: begin
					cbase_q <= '0;
					abase_q <= '0;
					ch_q    <= 1'b0;
					k_q     <= '0;
					j_q     <= '0;
				end
				OP_C4: lpm_q[ch_q][k_q] <= lp_new;
				OP_C6: begin
					cpos_q[ch_q][k_q] <= cpos_nx;
					cbase_q           <= cbase_q + CB_W'(clen);
					k_q               <= sts.comb_last ? KW'(0) : k_q + KW'(1);
				end
				OP_A1: begin
					apos_q[ch_q][j_q] <= apos_nx;
					abase_q           <= abase_q + AB_W'(alen);
					j_q               <= sts.ap_last ? JW'(0) : j_q + JW'(1);
					if (sts.ap_last) ch_q <= ~ch_q;
				end
				OP_M4: ch_q <= ~ch_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIN) begin
			out_q.left_out  <= res_q[0];
			out_q.right_out <= res_q[1];
		end
	end

	assign sts.clr_last  = (clr_q == CLR_W'(CLR_N - 1));
	assign sts.comb_last = (k_q == KW'(NC - 1));
	assign sts.ap_last   = (j_q == JW'(NA - 1));
	assign sts.ch_last   = ch_q;
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/stereo_schroeder_reverb.sv
// Stereo comb/allpass reverb. Each input beat is one stereo frame of signed
// 24-bit samples; each output beat is one frame holding the dry signal plus
// direct and cross-mixed reverb, saturated to 24 bits. The frame drives
// NUM_COMBS damped feedback combs and NUM_ALLPASSES allpasses per channel.
// One shared 33x21 multiplier with an accumulator does all gain products.
// The next frame is accepted once the result sits in the output register,
// so the reverb takes no new frame before it is through with the last; a
// result still held by a stalled output delays the final step. After reset
// the delay memories are swept to zero, one address a cycle over
// max(comb, allpass) depth addresses (9966 with the default line counts);
// the input is stalled during the sweep.
// Write gains only while no frame is in flight.
module stereo_schroeder_reverb import ssr_pkg::*; #(
	parameter int NUM_COMBS     = 4,
	parameter int NUM_ALLPASSES = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// clamp line counts to the supported table
	localparam int NC = (NUM_COMBS < 1) ? 1 : ((NUM_COMBS > 8) ? 8 : NUM_COMBS);
	localparam int NA = (NUM_ALLPASSES < 1) ? 1 : ((NUM_ALLPASSES > 4) ? 4 : NUM_ALLPASSES);
	localparam int COMB_DEPTH = comb_total(NC);
	localparam int AP_DEPTH   = ap_total(NA);
	localparam int CLR_N      = (COMB_DEPTH > AP_DEPTH) ? COMB_DEPTH : AP_DEPTH;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per datapath step
	ssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// delay memories, line state, shared multiplier and output register
	ssr_dp #(
		.NC         (NC),
		.NA         (NA),
		.COMB_DEPTH (COMB_DEPTH),
		.AP_DEPTH   (AP_DEPTH),
		.CLR_N      (CLR_N)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// a frame in flight holds off the next beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted back to back");

	// a result appears only from the final step of a frame
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == OP_FIN))
		else $error("output raised outside frame completion");

	// no beat is taken while the memories are swept
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CLEAR) |-> in_stall)
		else $error("input open during memory sweep");
`endif

endmodule
